// File: rtl/fep_pkg.sv
package fep_pkg;

    localparam int PROB_W         = 17;
    localparam int CNT_W          = 7;
    localparam int OUT_IDX_W      = 6;
    localparam int DEF_MAX_EVENTS = 64;
    localparam int PROD_W         = 2 * PROB_W;

    localparam logic [PROB_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [PROB_W-1:0] ZERO_Q16 = 17'd0;
    localparam logic [PROD_W-1:0] HALF_Q16 = 34'd32768;

    // one finished set, handed from the front to the back
    typedef struct packed {
        logic              bank;
        logic [CNT_W-1:0]  count;
        logic [PROB_W-1:0] any_fail;
    } t_job;

endpackage

// File: rtl/fep_ram.sv
module fep_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/fep_front.sv
module fep_front import fep_pkg::*; #(
    parameter int MAX_EVENTS = DEF_MAX_EVENTS,
    parameter int IDX_W      = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PROB_W-1:0]  i_event_prob,
    input  logic               i_last_event,
    input  logic               i_q_full,
    output logic               o_busy,
    output logic               o_we,
    output logic [IDX_W:0]     o_waddr,
    output logic [PROB_W-1:0]  o_wdata,
    output logic               o_push,
    output t_job               o_job
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL_STORE,
        S_MUL_PROD
    } t_state;

    t_state              r_state;
    logic [PROB_W-1:0]   r_p;
    logic                r_last;
    logic                r_keep;
    logic [PROB_W-1:0]   r_nfp;
    logic [CNT_W-1:0]    r_count;
    logic                r_bank;

    logic                w_accept;
    logic [PROB_W-1:0]   w_factor;
    logic [PROD_W-1:0]   w_prod;
    logic [PROD_W-1:0]   w_rsum;
    logic [PROB_W-1:0]   w_round;
    logic [PROB_W-1:0]   n_nfp;
    logic [PROB_W-1:0]   w_nfp_sat;

    assign o_busy   = (r_state != S_IDLE) || i_q_full;
    assign w_accept = i_start && !o_busy;

    // one shared multiplier: stored value first, then the no-fail product
    assign w_factor = (r_state == S_MUL_STORE) ? r_p : (ONE_Q16 - r_p);
    assign w_prod   = PROD_W'(r_nfp) * PROD_W'(w_factor);
    assign w_rsum   = w_prod + HALF_Q16;
    assign w_round  = w_rsum[PROB_W+15:16];

    assign n_nfp     = r_keep ? w_round : r_nfp;
    assign w_nfp_sat = (n_nfp > ONE_Q16) ? ONE_Q16 : n_nfp;

    assign o_we    = (r_state == S_MUL_STORE) && r_keep;
    assign o_waddr = {r_bank, r_count[IDX_W-1:0]};
    assign o_wdata = w_round;

    assign o_push         = (r_state == S_MUL_PROD) && r_last;
    assign o_job.bank     = r_bank;
    assign o_job.count    = r_keep ? (r_count + CNT_W'(1)) : r_count;
    assign o_job.any_fail = ONE_Q16 - w_nfp_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nfp   <= ONE_Q16;
            r_count <= '0;
            r_bank  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        // clamp probabilities above one
                        r_p     <= (i_event_prob > ONE_Q16) ? ONE_Q16 : i_event_prob;
                        r_last  <= i_last_event;
                        r_keep  <= (r_count < CNT_W'(MAX_EVENTS));
                        r_state <= S_MUL_STORE;
                    end
                end
                S_MUL_STORE: begin
                    r_state <= S_MUL_PROD;
                end
                S_MUL_PROD: begin
                    r_state <= S_IDLE;
                    if (r_last) begin
                        // hand the set off, start fresh in the other bank
                        r_nfp   <= ONE_Q16;
                        r_count <= '0;
                        r_bank  <= ~r_bank;
                    end else begin
                        r_nfp   <= n_nfp;
                        r_count <= o_job.count;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/fep_queue.sv
module fep_queue import fep_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    // two entries, one per storage bank
    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// File: rtl/fep_back.sv
module fep_back import fep_pkg::*; #(
    parameter int IDX_W = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  t_job                  i_job,
    output logic                  o_pop,
    output logic [IDX_W:0]        o_raddr,
    input  logic [PROB_W-1:0]     i_rdata,
    output logic                  o_result_strobe,
    output logic [OUT_IDX_W-1:0]  o_event_index,
    output logic [PROB_W-1:0]     o_relative_prob,
    output logic [PROB_W-1:0]     o_any_fail_prob,
    output logic                  o_last_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV
    } t_state;

    localparam int NUM_W  = PROB_W + 16;
    localparam int STEP_W = $clog2(PROB_W);

    t_state               r_state;
    logic [IDX_W-1:0]     r_idx;
    logic [PROB_W-1:0]    r_rem;
    logic [PROB_W-1:0]    r_low;
    logic [PROB_W-1:0]    r_quo;
    logic [STEP_W-1:0]    r_step;
    logic                 r_strobe;
    logic [OUT_IDX_W-1:0] r_index;
    logic [PROB_W-1:0]    r_rel;
    logic [PROB_W-1:0]    r_any;
    logic                 r_last;

    logic [NUM_W-1:0]     w_num;
    logic                 w_sat;
    logic                 w_zero;
    logic [PROB_W:0]      w_trial;
    logic                 w_fits;
    logic [PROB_W-1:0]    n_rem;
    logic [PROB_W-1:0]    n_quo;
    logic [PROB_W-1:0]    w_quo_sat;
    logic                 w_last;
    logic                 w_emit;

    assign o_raddr = {i_job.bank, r_idx};

    // numerator is value * 2^16 plus half the divisor; the low half never carries
    assign w_num  = {i_rdata, i_job.any_fail[PROB_W-1:1]};
    assign w_zero = (i_job.any_fail == ZERO_Q16);
    assign w_sat  = {1'b0, w_num} >= {i_job.any_fail, PROB_W'(0)};

    // one quotient bit per cycle, restoring
    assign w_trial   = {r_rem, r_low[PROB_W-1]};
    assign w_fits    = w_trial >= {1'b0, i_job.any_fail};
    assign n_rem     = w_fits ? PROB_W'(w_trial - {1'b0, i_job.any_fail})
                              : w_trial[PROB_W-1:0];
    assign n_quo     = {r_quo[PROB_W-2:0], w_fits};
    assign w_quo_sat = (n_quo > ONE_Q16) ? ONE_Q16 : n_quo;

    assign w_last = ((CNT_W'(r_idx) + CNT_W'(1)) == i_job.count);
    assign w_emit = ((r_state == S_LOAD) && (w_zero || w_sat))
                 || ((r_state == S_DIV) && (r_step == '0));
    assign o_pop  = w_emit && w_last;

    assign o_result_strobe = r_strobe;
    assign o_event_index   = r_index;
    assign o_relative_prob = r_rel;
    assign o_any_fail_prob = r_any;
    assign o_last_result   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_strobe <= w_emit;
            if (w_emit) begin
                r_index  <= OUT_IDX_W'(r_idx);
                r_any    <= i_job.any_fail;
                r_last   <= w_last;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_idx   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (w_zero || w_sat) begin
                        r_rel   <= w_zero ? i_rdata : ONE_Q16;
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= w_last ? S_IDLE : S_READ;
                    end else begin
                        r_rem   <= {1'b0, w_num[NUM_W-1:PROB_W]};
                        r_low   <= w_num[PROB_W-1:0];
                        r_quo   <= '0;
                        r_step  <= STEP_W'(PROB_W - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_low  <= {r_low[PROB_W-2:0], 1'b0};
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == '0) begin
                        r_rel   <= w_quo_sat;
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= w_last ? S_IDLE : S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/first_event_probability_normalizer_top.sv
// First-event probability normalizer. Load one event failure probability per beat
// (unsigned Q1.16, 65536 is one, larger values count as one) by raising start while
// busy is low; mark the final event of a set with i_last_event. Each accepted event
// keeps busy high while it passes the store and product steps, so the block takes
// no new event until that one is through. After the last event the set is handed
// to the output side and the block takes the next set at once, into a second
// storage bank; busy also stays high while two finished sets are still waiting to
// be emitted. Results come out in load order, one beat per stored event, each on
// the ports for exactly one cycle with o_result_strobe high; the receiver cannot
// stall them, so it must take every beat as it appears. Each result passes a RAM
// read, a setup step and seventeen quotient steps of the one-bit-per-cycle
// divider; when the any-failure probability is zero or the quotient would reach
// two or more it ends at the setup step, and the first result of a set also
// passes the idle state that picks the set up. Quotients between one and two
// still run the full divider and are then clipped to one. The final result of a
// set carries o_last_result. Stored values of events beyond MAX_EVENTS are
// dropped, but a last marker on such an event still closes the set.
module first_event_probability_normalizer_top import fep_pkg::*; #(
    parameter int MAX_EVENTS = DEF_MAX_EVENTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [PROB_W-1:0]    i_event_prob,
    input  logic                 i_last_event,
    output logic                 o_result_strobe,
    output logic [OUT_IDX_W-1:0] o_event_index,
    output logic [PROB_W-1:0]    o_relative_prob,
    output logic [PROB_W-1:0]    o_any_fail_prob,
    output logic                 o_last_result
);

    localparam int IDX_W     = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

    logic              w_q_full;
    logic              w_q_empty;
    logic              w_push;
    logic              w_pop;
    t_job              w_push_job;
    t_job              w_head_job;
    logic              w_we;
    logic [IDX_W:0]    w_waddr;
    logic [PROB_W-1:0] w_wdata;
    logic [IDX_W:0]    w_raddr;
    logic [PROB_W-1:0] w_rdata;

    // accept events, run the product chain, store unnormalized values
    fep_front #(
        .MAX_EVENTS (MAX_EVENTS),
        .IDX_W      (IDX_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_event_prob (i_event_prob),
        .i_last_event (i_last_event),
        .i_q_full     (w_q_full),
        .o_busy       (busy),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    // two banks: one filling, one draining
    fep_ram #(
        .WIDTH (PROB_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // finished sets wait here; the head is released after its last result
    fep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_head_job)
    );

    // read back, normalize and emit
    fep_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .i_job           (w_head_job),
        .o_pop           (w_pop),
        .o_raddr         (w_raddr),
        .i_rdata         (w_rdata),
        .o_result_strobe (o_result_strobe),
        .o_event_index   (o_event_index),
        .o_relative_prob (o_relative_prob),
        .o_any_fail_prob (o_any_fail_prob),
        .o_last_result   (o_last_result)
    );

endmodule
